>>> hdl/hrp_pkg.sv
package hrp_pkg;

  // default field limits
  localparam int unsigned METHOD_MAX_DEF  = 16;
  localparam int unsigned URI_MAX_DEF     = 256;
  localparam int unsigned NAME_MAX_DEF    = 256;
  localparam int unsigned VALUE_MAX_DEF   = 1024;
  localparam int unsigned HEADERS_MAX_DEF = 32;

  localparam int unsigned VERSION_LIMIT = 16;
  localparam int unsigned CL_LEN        = 14;

  localparam int unsigned POS_W   = 10;
  localparam int unsigned HCNT_W  = 6;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned LIMIT_W = POS_W + 1;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // queue between classifier and parser
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [3:0] {
    PH_METHOD  = 4'd0,
    PH_URI     = 4'd1,
    PH_VERSION = 4'd2,
    PH_LINE    = 4'd3,
    PH_NAME    = 4'd4,
    PH_SPACES  = 4'd5,
    PH_VALUE   = 4'd6,
    PH_HDREND  = 4'd7,
    PH_BODY    = 4'd8,
    PH_DONE    = 4'd9,
    PH_ERROR   = 4'd10
  } hrp_phase_e;

  typedef enum logic [2:0] {
    KIND_METHOD  = 3'd0,
    KIND_URI     = 3'd1,
    KIND_VERSION = 3'd2,
    KIND_NAME    = 3'd3,
    KIND_VALUE   = 3'd4,
    KIND_BODY    = 3'd5,
    KIND_DELIM   = 3'd6,
    KIND_IGNORED = 3'd7
  } hrp_kind_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_METHOD_LONG = 3'd1,
    ST_URI_LONG    = 3'd2,
    ST_VER_LONG    = 3'd3,
    ST_HDR_OVF     = 3'd4
  } hrp_status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } hrp_item_t;

  typedef struct packed {
    logic [2:0]       field_kind;
    logic [7:0]       out_byte;
    logic [POS_W-1:0] field_position;
    logic [4:0]       header_index;
    logic [2:0]       parse_status;
    logic [LEN_W-1:0] content_length;
    logic             headers_done;
    logic             message_done;
  } hrp_result_t;

  // classified byte, as queued for the parser
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       is_space;
    logic       is_cr;
    logic       is_colon;
    logic       is_digit;
    logic [3:0] digit;
  } hrp_cls_t;

  // "Content-Length"
  function automatic logic [7:0] cl_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h43; // C
      4'd1:    c = 8'h6F; // o
      4'd2:    c = 8'h6E; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6E; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2D; // -
      4'd8:    c = 8'h4C; // L
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6E; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> hdl/hrp_front.sv
module hrp_front
  import hrp_pkg::*;
(
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  hrp_item_t in_item_i,
  input  logic      q_full_i,
  output logic      q_push_o,
  output hrp_cls_t  q_cls_o
);

  logic [7:0] b;
  logic [7:0] diff;

  assign b    = in_item_i.data_byte;
  assign diff = b - CHAR_ZERO;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_cls_o.data_byte  = b;
    q_cls_o.first_byte = in_item_i.first_byte;
    q_cls_o.is_space   = (b == CHAR_SPACE);
    q_cls_o.is_cr      = (b == CHAR_CR);
    q_cls_o.is_colon   = (b == CHAR_COLON);
    q_cls_o.is_digit   = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    q_cls_o.digit      = diff[3:0];
  end

endmodule

>>> hdl/hrp_queue.sv
module hrp_queue
  import hrp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  hrp_cls_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output hrp_cls_t pop_data_o
);

  hrp_cls_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] r;
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + QPTR_W'(1);
    end
    return r;
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> hdl/hrp_back.sv
module hrp_back
  import hrp_pkg::*;
#(
  parameter int unsigned METHOD_MAX  = METHOD_MAX_DEF,
  parameter int unsigned URI_MAX     = URI_MAX_DEF,
  parameter int unsigned NAME_MAX    = NAME_MAX_DEF,
  parameter int unsigned VALUE_MAX   = VALUE_MAX_DEF,
  parameter int unsigned HEADERS_MAX = HEADERS_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  hrp_cls_t    q_cls_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output hrp_result_t out_result_o
);

  localparam logic [LIMIT_W-1:0] LIM_METHOD  = LIMIT_W'(METHOD_MAX);
  localparam logic [LIMIT_W-1:0] LIM_URI     = LIMIT_W'(URI_MAX);
  localparam logic [LIMIT_W-1:0] LIM_VERSION = LIMIT_W'(VERSION_LIMIT);
  localparam logic [LIMIT_W-1:0] LIM_NAME    = LIMIT_W'(NAME_MAX);
  localparam logic [LIMIT_W-1:0] LIM_VALUE   = LIMIT_W'(VALUE_MAX);
  localparam logic [HCNT_W-1:0]  LIM_HDRS    = HCNT_W'(HEADERS_MAX);
  localparam logic [POS_W-1:0]   CL_LEN_POS  = POS_W'(CL_LEN);

  // parser state
  hrp_phase_e        ph_q, ph_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [HCNT_W-1:0] hcnt_q, hcnt_d;
  logic              nm_q, nm_d;
  logic              da_q, da_d;
  logic [LEN_W-1:0]  acc_q, acc_d;
  logic [LEN_W-1:0]  lat_q, lat_d;
  logic [LEN_W-1:0]  brem_q, brem_d;
  logic [2:0]        err_q, err_d;
  logic              skip_q, skip_d;

  // state as seen by this byte (first_byte restarts the message)
  hrp_phase_e        ph;
  logic [POS_W-1:0]  pos;
  logic [HCNT_W-1:0] hcnt;
  logic              nm, da, skip;
  logic [LEN_W-1:0]  acc, lat, brem;
  logic [2:0]        err;

  // helpers shared by next state and result
  logic [POS_W-1:0]   name_pos, val_pos;
  logic               name_nm, val_da;
  logic [LEN_W-1:0]   val_acc, acc_next, brem_next;
  logic [LIMIT_W-1:0] pos_inc, name_inc, val_inc;
  logic [LEN_W+3:0]   acc_x10;
  logic               name_hit;

  hrp_kind_e        kind;
  logic [POS_W-1:0] rpos;
  logic             hd, md;

  logic        fire;
  logic        out_valid_q;
  hrp_result_t res_q;

  assign fire         = q_valid_i && (!out_valid_q || out_ready_i);
  assign q_pop_o      = fire;
  assign out_valid_o  = out_valid_q;
  assign out_result_o = res_q;

  always_comb begin
    if (q_cls_i.first_byte) begin
      ph   = PH_METHOD;
      pos  = '0;
      hcnt = '0;
      nm   = 1'b1;
      da   = 1'b0;
      acc  = '0;
      lat  = '0;
      brem = '0;
      err  = ST_OK;
      skip = 1'b0;
    end else begin
      ph   = ph_q;
      pos  = pos_q;
      hcnt = hcnt_q;
      nm   = nm_q;
      da   = da_q;
      acc  = acc_q;
      lat  = lat_q;
      brem = brem_q;
      err  = err_q;
      skip = skip_q;
    end
  end

  always_comb begin
    // a new header line starts its name at position 0 with the match flag set
    name_pos = (ph == PH_LINE) ? '0 : pos;
    name_nm  = (ph == PH_LINE) ? 1'b1 : nm;
    // first value byte restarts position and accumulator
    val_pos  = (ph == PH_SPACES) ? '0 : pos;
    val_acc  = (ph == PH_SPACES) ? '0 : acc;
    val_da   = (ph == PH_SPACES) ? nm : da;

    pos_inc  = {1'b0, pos} + LIMIT_W'(1);
    name_inc = {1'b0, name_pos} + LIMIT_W'(1);
    val_inc  = {1'b0, val_pos} + LIMIT_W'(1);

    name_hit = (name_pos < CL_LEN_POS) && (q_cls_i.data_byte == cl_char(name_pos[3:0]));

    // acc*10 + digit, saturating
    acc_x10  = {val_acc, 3'b000} + {2'b00, val_acc, 1'b0} + (LEN_W+4)'(q_cls_i.digit);
    acc_next = (acc_x10[LEN_W+3:LEN_W] != '0) ? '1 : acc_x10[LEN_W-1:0];

    brem_next = (brem != '0) ? brem - LEN_W'(1) : brem;
  end

  // next state
  always_comb begin
    ph_d   = ph;
    pos_d  = pos;
    hcnt_d = hcnt;
    nm_d   = nm;
    da_d   = da;
    acc_d  = acc;
    lat_d  = lat;
    brem_d = brem;
    err_d  = err;
    skip_d = skip;

    if (skip || ph == PH_HDREND) begin
      skip_d = 1'b0;
      if (ph == PH_HDREND) begin
        if (lat == '0) begin
          ph_d = PH_DONE;
        end else begin
          brem_d = lat;
          pos_d  = '0;
          ph_d   = PH_BODY;
        end
      end
    end else begin
      unique case (ph)
        PH_METHOD: begin
          if (q_cls_i.is_space) begin
            pos_d = '0;
            ph_d  = PH_URI;
          end else begin
            pos_d = pos_inc[POS_W-1:0];
            if (pos_inc >= LIM_METHOD) begin
              err_d = ST_METHOD_LONG;
              ph_d  = PH_ERROR;
            end
          end
        end
        PH_URI: begin
          if (q_cls_i.is_space) begin
            pos_d = '0;
            ph_d  = PH_VERSION;
          end else begin
            pos_d = pos_inc[POS_W-1:0];
            if (pos_inc >= LIM_URI) begin
              err_d = ST_URI_LONG;
              ph_d  = PH_ERROR;
            end
          end
        end
        PH_VERSION: begin
          if (q_cls_i.is_cr) begin
            pos_d  = '0;
            skip_d = 1'b1;
            ph_d   = PH_LINE;
          end else begin
            pos_d = pos_inc[POS_W-1:0];
            if (pos_inc >= LIM_VERSION) begin
              err_d = ST_VER_LONG;
              ph_d  = PH_ERROR;
            end
          end
        end
        PH_LINE, PH_NAME: begin
          if (ph == PH_LINE && q_cls_i.is_cr) begin
            ph_d = PH_HDREND;
          end else if (ph == PH_LINE && hcnt >= LIM_HDRS) begin
            err_d = ST_HDR_OVF;
            ph_d  = PH_ERROR;
          end else if (q_cls_i.is_colon) begin
            pos_d = name_pos;
            nm_d  = name_nm && (name_pos == CL_LEN_POS);
            ph_d  = PH_SPACES;
          end else begin
            nm_d  = name_nm && name_hit;
            pos_d = name_inc[POS_W-1:0];
            ph_d  = PH_NAME;
            if (name_inc >= LIM_NAME) begin
              err_d = ST_HDR_OVF;
              ph_d  = PH_ERROR;
            end
          end
        end
        PH_SPACES, PH_VALUE: begin
          if (ph == PH_SPACES && q_cls_i.is_space) begin
            // leading blanks before the value
          end else if (q_cls_i.is_cr) begin
            da_d   = val_da;
            acc_d  = val_acc;
            if (nm) begin
              lat_d = val_acc;
            end
            hcnt_d = hcnt + HCNT_W'(1);
            skip_d = 1'b1;
            pos_d  = '0;
            ph_d   = PH_LINE;
          end else begin
            acc_d = val_acc;
            da_d  = val_da;
            if (val_da) begin
              if (q_cls_i.is_digit) begin
                acc_d = acc_next;
              end else begin
                da_d = 1'b0;
              end
            end
            pos_d = val_inc[POS_W-1:0];
            ph_d  = PH_VALUE;
            if (val_inc >= LIM_VALUE) begin
              err_d = ST_HDR_OVF;
              ph_d  = PH_ERROR;
            end
          end
        end
        PH_BODY: begin
          pos_d  = pos_inc[POS_W-1:0];
          brem_d = brem_next;
          if (brem_next == '0) begin
            ph_d = PH_DONE;
          end
        end
        default: begin
          // done or error: hold until the next message
        end
      endcase
    end
  end

  // result of this byte
  always_comb begin
    kind = KIND_IGNORED;
    rpos = '0;
    hd   = 1'b0;
    md   = 1'b0;

    if (skip || ph == PH_HDREND) begin
      if (ph == PH_HDREND) begin
        hd = 1'b1;
        md = (lat == '0);
      end
    end else begin
      unique case (ph)
        PH_METHOD: begin
          kind = q_cls_i.is_space ? KIND_DELIM : KIND_METHOD;
          rpos = q_cls_i.is_space ? '0 : pos;
        end
        PH_URI: begin
          kind = q_cls_i.is_space ? KIND_DELIM : KIND_URI;
          rpos = q_cls_i.is_space ? '0 : pos;
        end
        PH_VERSION: begin
          kind = q_cls_i.is_cr ? KIND_DELIM : KIND_VERSION;
          rpos = q_cls_i.is_cr ? '0 : pos;
        end
        PH_LINE, PH_NAME: begin
          if (ph == PH_LINE && q_cls_i.is_cr) begin
            kind = KIND_DELIM;
          end else if (ph == PH_LINE && hcnt >= LIM_HDRS) begin
            kind = KIND_NAME;
          end else if (q_cls_i.is_colon) begin
            kind = KIND_DELIM;
          end else begin
            kind = KIND_NAME;
            rpos = name_pos;
          end
        end
        PH_SPACES, PH_VALUE: begin
          if ((ph == PH_SPACES && q_cls_i.is_space) || q_cls_i.is_cr) begin
            kind = KIND_DELIM;
          end else begin
            kind = KIND_VALUE;
            rpos = val_pos;
          end
        end
        PH_BODY: begin
          kind = KIND_BODY;
          rpos = pos;
          md   = (brem_next == '0);
        end
        default: begin
          kind = KIND_IGNORED;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        <= PH_METHOD;
      pos_q       <= '0;
      hcnt_q      <= '0;
      nm_q        <= 1'b1;
      da_q        <= 1'b0;
      acc_q       <= '0;
      lat_q       <= '0;
      brem_q      <= '0;
      err_q       <= ST_OK;
      skip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        ph_q   <= ph_d;
        pos_q  <= pos_d;
        hcnt_q <= hcnt_d;
        nm_q   <= nm_d;
        da_q   <= da_d;
        acc_q  <= acc_d;
        lat_q  <= lat_d;
        brem_q <= brem_d;
        err_q  <= err_d;
        skip_q <= skip_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q.field_kind     <= kind;
      res_q.out_byte       <= q_cls_i.data_byte;
      res_q.field_position <= rpos;
      res_q.header_index   <= hcnt[4:0];
      res_q.parse_status   <= err_d;
      res_q.content_length <= lat_d;
      res_q.headers_done   <= hd;
      res_q.message_done   <= md;
    end
  end

endmodule

>>> hdl/http_request_parser.sv
// HTTP request parser, one byte per transfer.
//
// Input channel (in_valid_i / in_ready_o / in_item_i): one byte of the request
// per transfer; first_byte set on the opening byte of a message restarts the
// parser before that byte is handled.
// Output channel (out_valid_o / out_ready_i / out_result_o): exactly one result
// per input byte, in order: field kind, the byte, its position in its field,
// header line number, status, Content-Length value, headers_done and
// message_done flags.
// Path: each byte is written into the queue, and its result is then written
// into the output register, which drives out_valid_o.
// Throughput: 1 byte per cycle. The front classifies each byte and writes it
// into a 2-entry queue; the back parser reads one entry per cycle into the
// output register. The parser's state update is the per-byte loop.
// Stall: a held output register stops the parser; the queue then fills and
// in_ready_o drops. Neither side loses or repeats a transfer.
// Reset: queue and output empty, parser at the method field, no clearing pass.
module http_request_parser
  import hrp_pkg::*;
#(
  parameter int unsigned METHOD_MAX  = METHOD_MAX_DEF,
  parameter int unsigned URI_MAX     = URI_MAX_DEF,
  parameter int unsigned NAME_MAX    = NAME_MAX_DEF,
  parameter int unsigned VALUE_MAX   = VALUE_MAX_DEF,
  parameter int unsigned HEADERS_MAX = HEADERS_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  hrp_item_t   in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output hrp_result_t out_result_o
);

  // front -> queue
  logic     q_push;
  logic     q_full;
  hrp_cls_t q_wr_cls;

  // queue -> back
  logic     q_valid;
  logic     q_pop;
  hrp_cls_t q_rd_cls;

  hrp_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cls_o    (q_wr_cls)
  );

  hrp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wr_cls),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_rd_cls)
  );

  // parser plus output register
  hrp_back #(
    .METHOD_MAX  (METHOD_MAX),
    .URI_MAX     (URI_MAX),
    .NAME_MAX    (NAME_MAX),
    .VALUE_MAX   (VALUE_MAX),
    .HEADERS_MAX (HEADERS_MAX)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_cls_i      (q_rd_cls),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_result_o (out_result_o)
  );

endmodule

>>> dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hrp_pkg::*;

  // ---------------------------------------------------------------------------
  // Run control
  // ---------------------------------------------------------------------------
  localparam int CLK_PERIOD   = 4;           // ns
  localparam int RESET_CYCLES = 11;
  localparam int STIM_ITEMS   = 1650;        // bytes offered in all
  localparam int DRAIN_EVERY  = 400;         // sender empties the pipe at these byte counts
  localparam int DRAIN_CYCLES = 20;          // well past the delay through the queue and the output register
  localparam int MAX_REPORTS  = 200;         // keeps a broken run readable
  localparam int TIMEOUT_NS   = 12_000_000;  // hang guard, far beyond the slowest run

  // name that arms the body length
  localparam logic [8*CL_LEN-1:0] CL_NAME = "Content-Length";

  // request shapes that cost many bytes; each one is sent once
  typedef enum int {
    SP_NONE,
    SP_BODY_WRAP,   // body longer than 1024, positions wrap
    SP_VALUE_LONG,  // header value at the value limit
    SP_NAME_LONG,   // header name at the name limit
    SP_URI_LONG,    // URI at the URI limit
    SP_HDR_MANY     // 32 or 33 header lines
  } special_e;

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  hrp_item_t   in_item   = '0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  hrp_result_t out_result;

  http_request_parser uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .in_item_i    (in_item),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .out_result_o (out_result)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Parser shadow state, same widths as the block
  // ---------------------------------------------------------------------------
  hrp_phase_e        ph;
  logic [POS_W-1:0]  pos_cnt;
  logic [HCNT_W-1:0] hdr_cnt;
  logic              name_match;
  logic              digits_on;
  logic [LEN_W-1:0]  len_accum;
  logic [LEN_W-1:0]  len_latched;
  logic [LEN_W-1:0]  body_left;
  hrp_status_e       err_code;
  logic              skip_byte;

  hrp_item_t   request_bytes [$];   // everything the sender will offer, in order
  hrp_result_t pending_results [$]; // predicted results not yet seen on the output

  int   next_idx    = 0;
  int   send_gap    = 0;
  int   send_calm   = 0;
  int   recv_stall  = 0;
  int   recv_calm   = 0;
  int   error_count = 0;
  int   result_num  = 0;
  logic in_taken    = 1'b0;

  // generator scratch
  int   cut_left;
  logic first_pending;

  function automatic void reset_parser();
    ph          = PH_METHOD;
    pos_cnt     = '0;
    hdr_cnt     = '0;
    name_match  = 1'b1;
    digits_on   = 1'b0;
    len_accum   = '0;
    len_latched = '0;
    body_left   = '0;
    err_code    = ST_OK;
    skip_byte   = 1'b0;
  endfunction

  // tag a byte as part of a field; the byte whose position+1 hits the limit errors
  function automatic void take_field(inout hrp_result_t r, input hrp_kind_e kind,
                                     input int limit, input hrp_status_e err);
    r.field_kind     = kind;
    r.field_position = pos_cnt;
    pos_cnt          = pos_cnt + 1'b1;
    if (int'(r.field_position) + 1 >= limit) begin
      err_code = err;
      ph       = PH_ERROR;
    end
  endfunction

  function automatic void name_byte(inout hrp_result_t r, input logic [7:0] b);
    int idx;
    idx = int'(pos_cnt);
    if (b == CHAR_COLON) begin
      r.field_kind = KIND_DELIM;
      name_match   = name_match && (pos_cnt == CL_LEN);
      ph           = PH_SPACES;
    end else begin
      if (pos_cnt >= CL_LEN) begin
        name_match = 1'b0;
      end else if (b != CL_NAME[8*(int'(CL_LEN) - 1 - idx) +: 8]) begin
        name_match = 1'b0;
      end
      take_field(r, KIND_NAME, NAME_MAX_DEF, ST_HDR_OVF);
    end
  endfunction

  function automatic void value_byte(inout hrp_result_t r, input logic [7:0] b);
    logic [LEN_W-1:0] d;
    if (b == CHAR_CR) begin
      r.field_kind = KIND_DELIM;
      if (name_match) len_latched = len_accum;
      hdr_cnt   = hdr_cnt + 1'b1;
      skip_byte = 1'b1;
      ph        = PH_LINE;
      pos_cnt   = '0;
    end else begin
      if (digits_on) begin
        if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
          d = 32'(b) - 32'(CHAR_ZERO);
          // saturate at all ones
          if (len_accum > (32'hFFFF_FFFF - d) / 10) len_accum = '1;
          else len_accum = len_accum * 10 + d;
        end else begin
          digits_on = 1'b0;
        end
      end
      take_field(r, KIND_VALUE, VALUE_MAX_DEF, ST_HDR_OVF);
    end
  endfunction

  // expected result for one accepted byte; advances the shadow state
  function automatic hrp_result_t parse_byte(input hrp_item_t it);
    hrp_result_t r;
    logic [7:0]  b;
    b = it.data_byte;
    if (it.first_byte) reset_parser();
    r              = '0;
    r.field_kind   = KIND_IGNORED;
    r.out_byte     = b;
    r.header_index = hdr_cnt[4:0];
    if (skip_byte || ph == PH_HDREND) begin
      // byte after a CR; after the blank line it also closes the header block
      skip_byte = 1'b0;
      if (ph == PH_HDREND) begin
        r.headers_done = 1'b1;
        if (len_latched == '0) begin
          r.message_done = 1'b1;
          ph             = PH_DONE;
        end else begin
          body_left = len_latched;
          pos_cnt   = '0;
          ph        = PH_BODY;
        end
      end
    end else begin
      case (ph)
        PH_METHOD: begin
          if (b == CHAR_SPACE) begin
            r.field_kind = KIND_DELIM;
            pos_cnt      = '0;
            ph           = PH_URI;
          end else begin
            take_field(r, KIND_METHOD, METHOD_MAX_DEF, ST_METHOD_LONG);
          end
        end
        PH_URI: begin
          if (b == CHAR_SPACE) begin
            r.field_kind = KIND_DELIM;
            pos_cnt      = '0;
            ph           = PH_VERSION;
          end else begin
            take_field(r, KIND_URI, URI_MAX_DEF, ST_URI_LONG);
          end
        end
        PH_VERSION: begin
          if (b == CHAR_CR) begin
            r.field_kind = KIND_DELIM;
            pos_cnt      = '0;
            skip_byte    = 1'b1;
            ph           = PH_LINE;
          end else begin
            take_field(r, KIND_VERSION, VERSION_LIMIT, ST_VER_LONG);
          end
        end
        PH_LINE: begin
          if (b == CHAR_CR) begin
            r.field_kind = KIND_DELIM;
            ph           = PH_HDREND;
          end else if (hdr_cnt >= HEADERS_MAX_DEF) begin
            // one line too many: first byte still reads as a name byte
            r.field_kind = KIND_NAME;
            err_code     = ST_HDR_OVF;
            ph           = PH_ERROR;
          end else begin
            name_match = 1'b1;
            pos_cnt    = '0;
            ph         = PH_NAME;
            name_byte(r, b);
          end
        end
        PH_NAME: name_byte(r, b);
        PH_SPACES: begin
          if (b == CHAR_SPACE) begin
            r.field_kind = KIND_DELIM;
          end else begin
            pos_cnt   = '0;
            len_accum = '0;
            digits_on = name_match;
            ph        = PH_VALUE;
            value_byte(r, b);
          end
        end
        PH_VALUE: value_byte(r, b);
        PH_BODY: begin
          r.field_kind     = KIND_BODY;
          r.field_position = pos_cnt;
          pos_cnt          = pos_cnt + 1'b1;
          if (body_left != '0) body_left = body_left - 1'b1;
          if (body_left == '0) begin
            r.message_done = 1'b1;
            ph             = PH_DONE;
          end
        end
        default: ;  // done or error: ignored until the next first byte
      endcase
    end
    r.parse_status   = err_code;
    r.content_length = len_latched;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request generator
  // ---------------------------------------------------------------------------
  // cut_left > 0 truncates the request after that many bytes; -1 means whole
  task automatic add_byte(input logic [7:0] b);
    if (cut_left == 0) return;
    if (cut_left > 0) cut_left--;
    request_bytes.push_back('{data_byte: b, first_byte: first_pending});
    first_pending = 1'b0;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // CR plus the byte after it, which the parser skips whatever it is
  task automatic add_line_end();
    add_byte(CHAR_CR);
    if ($urandom_range(9) == 0) add_byte(8'($urandom));
    else add_byte(8'h0A);
  endtask

  // mostly printable, sometimes CR or any byte; never one of the two barred
  function automatic logic [7:0] rand_char(input logic [7:0] bar_a, input logic [7:0] bar_b);
    logic [7:0] c;
    do begin
      case ($urandom_range(19))
        0:       c = CHAR_CR;
        1, 2:    c = 8'($urandom_range(255));
        default: c = 8'($urandom_range(8'h21, 8'h7E));
      endcase
    end while (c == bar_a || c == bar_b);
    return c;
  endfunction

  task automatic gen_request(input special_e sp);
    int    nhdr;
    int    body_len;
    int    pick;
    int    n;
    int    name_len;
    string txt;
    if (sp == SP_NONE && $urandom_range(11) == 0) cut_left = $urandom_range(1, 40);
    else cut_left = -1;
    first_pending = 1'b1;
    body_len      = 0;

    // request line
    if (sp == SP_NONE && $urandom_range(9) == 0) n = $urandom_range(14, 17);
    else n = $urandom_range(0, 7);
    repeat (n) add_byte(rand_char(CHAR_SPACE, CHAR_SPACE));
    add_byte(CHAR_SPACE);
    if (sp == SP_URI_LONG) n = $urandom_range(URI_MAX_DEF - 1, URI_MAX_DEF + 1);
    else n = $urandom_range(0, 12);
    repeat (n) add_byte(rand_char(CHAR_SPACE, CHAR_SPACE));
    add_byte(CHAR_SPACE);
    if (sp != SP_NONE || $urandom_range(4) != 0) add_text("HTTP/1.1");
    else repeat ($urandom_range(0, 17)) add_byte(rand_char(CHAR_CR, CHAR_CR));
    add_line_end();

    // header lines
    case (sp)
      SP_NONE:     nhdr = $urandom_range(0, 5);
      SP_HDR_MANY: nhdr = $urandom_range(HEADERS_MAX_DEF, HEADERS_MAX_DEF + 1);
      default:     nhdr = $urandom_range(1, 3);
    endcase
    for (int h = 0; h < nhdr; h++) begin
      if (sp == SP_HDR_MANY) pick = 9;
      else if (sp == SP_NAME_LONG && h == 0) pick = 8;
      else if (sp == SP_BODY_WRAP) pick = (h == 0) ? 0 : 9;
      else pick = $urandom_range(9);

      if (sp == SP_HDR_MANY) name_len = 1;
      else if (sp == SP_NAME_LONG && h == 0)
        name_len = $urandom_range(NAME_MAX_DEF - 1, NAME_MAX_DEF + 1);
      else name_len = $urandom_range(0, 10);

      if (pick < 4) begin
        add_text("Content-Length");
      end else if (pick == 4) begin
        case ($urandom_range(3))
          0:       add_text("content-length");
          1:       add_text("Content-Lengt");
          2:       add_text("Content-Lengthh");
          default: add_text("Content-Lenhth");
        endcase
      end else begin
        // a CR first would read as the blank line, so only later bytes may be CR
        for (int k = 0; k < name_len; k++)
          add_byte(rand_char(CHAR_COLON, (k == 0) ? CHAR_CR : CHAR_COLON));
      end
      add_byte(CHAR_COLON);
      repeat ($urandom_range(0, 2)) add_byte(CHAR_SPACE);

      if (sp == SP_VALUE_LONG && h == 0) begin
        repeat ($urandom_range(VALUE_MAX_DEF - 1, VALUE_MAX_DEF + 1))
          add_byte(rand_char(CHAR_CR, CHAR_SPACE));
      end else if (pick < 4) begin
        case ($urandom_range(7))
          0: begin
            n   = 0;
            txt = "";
          end
          1: begin  // far past 32 bits
            n   = -1;
            txt = $sformatf("%0d%0d", $urandom_range(42950, 99999),
                            $urandom_range(100000, 999999));
          end
          2: begin  // right at and one past the saturation point
            n   = -1;
            txt = ($urandom_range(1) == 0) ? "4294967295" : "4294967296";
          end
          3: begin  // digits stop at the first non-digit
            n   = $urandom_range(0, 24);
            txt = $sformatf("%0dx7", n);
          end
          4: begin
            n   = $urandom_range(0, 24);
            txt = $sformatf("00%0d", n);
          end
          default: begin
            n   = $urandom_range(0, 24);
            txt = $sformatf("%0d", n);
          end
        endcase
        if (sp == SP_BODY_WRAP) begin
          n   = $urandom_range(1025, 1030);
          txt = $sformatf("%0d", n);
        end
        add_text(txt);
        body_len = n;
      end else begin
        repeat ($urandom_range(0, 10)) add_byte(rand_char(CHAR_CR, CHAR_CR));
      end
      add_line_end();
    end
    add_line_end();

    // body: full, short, or a few bytes of a body too long to finish
    if (body_len < 0) n = $urandom_range(3, 8);
    else if ($urandom_range(9) == 0) n = $urandom_range(0, body_len);
    else n = body_len;
    repeat (n) add_byte(8'($urandom));
    // stray bytes after completion
    if ($urandom_range(4) == 0) repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
  endtask

  // random bytes with a random first_byte
  task automatic add_noise();
    repeat ($urandom_range(1, 8))
      request_bytes.push_back('{data_byte: 8'($urandom), first_byte: ($urandom_range(3) == 0)});
  endtask

  function automatic int gap_len();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return $urandom_range(1, 2);
    if (pick < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 80);
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one byte on offer at a time, changed only at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : send_proc
    logic      nv;
    hrp_item_t ni;
    nv = in_valid;
    ni = in_item;
    if (rst_n) begin
      if (in_taken) nv = 1'b0;
      // every DRAIN_EVERY bytes hold off until the output side has caught up
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (next_idx < request_bytes.size() &&
                     !(next_idx % DRAIN_EVERY == 0 && next_idx != 0 &&
                       pending_results.size() != 0)) begin
          ni = request_bytes[next_idx];
          nv = 1'b1;
          next_idx++;
          if (send_calm > 0) send_calm--;
          else if ($urandom_range(63) == 0) send_calm = $urandom_range(40, 120);
          else if ($urandom_range(2) == 0) send_gap = gap_len();
        end
      end
    end
    in_valid <= nv;
    in_item  <= ni;
  end

  // Receiver: random stalls, with calm stretches of steady ready
  always @(negedge clk) begin : recv_proc
    logic nr;
    nr = 1'b1;
    if (recv_stall > 0) begin
      recv_stall--;
      nr = 1'b0;
    end else if (recv_calm > 0) begin
      recv_calm--;
    end else if ($urandom_range(63) == 0) begin
      recv_calm = $urandom_range(40, 120);
    end else if ($urandom_range(3) == 0) begin
      recv_stall = gap_len() - 1;
      nr         = 1'b0;
    end
    out_ready <= nr;
  end

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0d ns: result %0d %s expected %0h actual %0h",
                 $time, result_num, what, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: both transfers seen at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : mon_proc
    hrp_result_t want;
    in_taken = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0d ns: result %0d with nothing expected, actual %h",
                     $time, result_num, out_result);
        end else begin
          want = pending_results.pop_front();
          check_field("field_kind", want.field_kind, out_result.field_kind);
          check_field("out_byte", want.out_byte, out_result.out_byte);
          check_field("field_position", want.field_position, out_result.field_position);
          check_field("header_index", want.header_index, out_result.header_index);
          check_field("parse_status", want.parse_status, out_result.parse_status);
          check_field("content_length", want.content_length, out_result.content_length);
          check_field("headers_done", want.headers_done, out_result.headers_done);
          check_field("message_done", want.message_done, out_result.message_done);
        end
        result_num++;
      end
      if (in_valid && in_ready) begin
        pending_results.push_back(parse_byte(in_item));
        in_taken = 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus build, reset, end of run
  // ---------------------------------------------------------------------------
  initial begin : main_proc
    int       msg_num;
    int       plain_bytes;
    int       size_before;
    special_e sp;
    reset_parser();

    // directed: smallest request, then bytes ignored after completion
    cut_left      = -1;
    first_pending = 1'b1;
    add_text("A / B");
    add_byte(CHAR_CR);
    add_byte(8'h0A);
    add_byte(CHAR_CR);
    add_byte(8'h0A);
    add_byte(8'hFF);
    add_byte(8'h00);
    // directed: CR inside the method, empty URI, empty name and value,
    // odd skipped bytes
    first_pending = 1'b1;
    add_byte(8'h00);
    add_byte(CHAR_CR);
    add_byte(CHAR_SPACE);
    add_byte(CHAR_SPACE);
    add_byte(8'hFF);
    add_byte(CHAR_CR);
    add_byte(8'h0A);
    add_byte(CHAR_COLON);
    add_byte(CHAR_CR);
    add_byte(8'h00);
    add_byte(CHAR_CR);
    add_byte(8'hFF);

    // random requests; the long shapes go in early, once each
    msg_num     = 0;
    plain_bytes = request_bytes.size();
    while (plain_bytes < STIM_ITEMS || msg_num <= 2 * int'(SP_HDR_MANY)) begin
      if (msg_num % 2 == 0 && msg_num >= 2 && msg_num <= 2 * int'(SP_HDR_MANY))
        sp = special_e'(msg_num / 2);
      else
        sp = SP_NONE;
      size_before = request_bytes.size();
      gen_request(sp);
      if ($urandom_range(7) == 0) add_noise();
      plain_bytes += request_bytes.size() - size_before;
      msg_num++;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (next_idx < request_bytes.size() || in_valid || pending_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("http_request_parser test passed");
    end else begin
      $display("http_request_parser test failed");
    end
    $finish;
  end

  initial begin : timeout_proc
    #(TIMEOUT_NS);
    $display("http_request_parser test failed");
    $finish;
  end

endmodule
